// ----- hw/rtl/line_rasterizer_framebuffer_core_macros.svh -----
// Assertion macros for the line rasterizer frame buffer core.
// Both assume the enclosing module has i_clk and synchronous active-low i_rst_n.
`ifndef LINE_RASTERIZER_FRAMEBUFFER_CORE_MACROS_SVH
`define LINE_RASTERIZER_FRAMEBUFFER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Property checked on every clock edge outside reset.
`define LRFB_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("lrfb assertion failed");

// Condition that must never be true outside reset.
`define LRFB_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error("lrfb forbidden condition seen");

`else

`define LRFB_ASSERT(lbl, prop)
`define LRFB_ASSERT_NEVER(lbl, cond)

`endif

`endif

// ----- hw/rtl/lrfb_pkg.sv -----
// Shared types, constants and address helpers for the line rasterizer core.
// No dependencies; imported by lrfb_line_stepper and line_rasterizer_framebuffer_core.
package lrfb_pkg;

    localparam int SCREEN_WIDTH  = 320;
    localparam int SCREEN_HEIGHT = 240;
    localparam int FRAME_WORDS   = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int ADDR_W        = $clog2(FRAME_WORDS);

    localparam int COORD_W = 12;
    localparam int COLOR_W = 16;
    localparam int COUNT_W = 12;
    localparam int ERR_W   = COORD_W + 2;

    localparam logic OP_DRAW = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [COORD_W-2:0] LIM_X = (COORD_W-1)'(SCREEN_WIDTH);
    localparam logic [COORD_W-2:0] LIM_Y = (COORD_W-1)'(SCREEN_HEIGHT);
    localparam logic [ADDR_W-1:0]  ROW_PITCH = ADDR_W'(SCREEN_WIDTH);

    typedef struct packed {
        logic                      op;
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
        logic [COLOR_W-1:0]        pixel_color;
    } t_in_item;

    typedef struct packed {
        logic [COLOR_W-1:0] read_pixel;
        logic [COUNT_W-1:0] pixels_written;
    } t_out_item;

    typedef struct packed {
        logic               we;
        logic [ADDR_W-1:0]  addr;
        logic [COLOR_W-1:0] data;
    } t_wr_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_step_stat;

    function automatic logic on_screen(input logic signed [COORD_W-1:0] x,
                                       input logic signed [COORD_W-1:0] y);
        return !x[COORD_W-1] && !y[COORD_W-1] &&
               (x[COORD_W-2:0] < LIM_X) && (y[COORD_W-2:0] < LIM_Y);
    endfunction

    // Row-major word address; meaningful only for on-screen points.
    function automatic logic [ADDR_W-1:0] pix_addr(input logic signed [COORD_W-1:0] x,
                                                   input logic signed [COORD_W-1:0] y);
        return ADDR_W'(y[COORD_W-2:0]) * ROW_PITCH + ADDR_W'(x[COORD_W-2:0]);
    endfunction

endpackage

// ----- hw/rtl/lrfb_frame_ram.sv -----
// Single-port synchronous RAM holding the frame, with a registered read.
// Generic; sized by its parameters from lrfb_pkg at the top level.
module lrfb_frame_ram #(
    parameter int DEPTH  = 76800,
    parameter int DATA_W = 16,
    parameter int ADDR_W = 17
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [DATA_W-1:0] i_wdata,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end else if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/lrfb_line_stepper.sv -----
// Error-term line stepper: one visited point per cycle, emits frame writes.
// Depends on lrfb_pkg and the assertion macro header.
`include "line_rasterizer_framebuffer_core_macros.svh"

module lrfb_line_stepper
    import lrfb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  t_in_item   i_cmd,
    input  logic       i_release,
    output t_step_stat o_stat,
    output logic [COUNT_W-1:0] o_count,
    output t_wr_req    o_wr
);

    logic                      r_busy;
    logic signed [COORD_W-1:0] r_x, r_y, r_xe, r_ye;
    logic [COORD_W-1:0]        r_dx, r_dy;
    logic                      r_sx_neg, r_sy_neg;
    logic signed [ERR_W-1:0]   r_err;
    logic [COLOR_W-1:0]        r_color;
    logic [COUNT_W-1:0]        r_count;

    logic                      n_busy;
    logic signed [COORD_W-1:0] n_x, n_y;
    logic signed [ERR_W-1:0]   n_err;
    logic [COUNT_W-1:0]        n_count;

    // Setup from the command.
    logic signed [COORD_W:0]   w_ddx, w_ddy, w_ndx, w_ndy;
    logic [COORD_W-1:0]        w_adx, w_ady;

    // Step decision.
    logic                      w_at_end, w_vis;
    logic signed [ERR_W:0]     w_e2, w_ndy_e, w_dx_e;
    logic                      w_mx, w_my;
    logic signed [ERR_W-1:0]   w_err_a;

    assign w_ddx = {i_cmd.end_x[COORD_W-1], i_cmd.end_x}
                 - {i_cmd.start_x[COORD_W-1], i_cmd.start_x};
    assign w_ddy = {i_cmd.end_y[COORD_W-1], i_cmd.end_y}
                 - {i_cmd.start_y[COORD_W-1], i_cmd.start_y};
    assign w_ndx = -w_ddx;
    assign w_ndy = -w_ddy;
    assign w_adx = w_ddx[COORD_W] ? w_ndx[COORD_W-1:0] : w_ddx[COORD_W-1:0];
    assign w_ady = w_ddy[COORD_W] ? w_ndy[COORD_W-1:0] : w_ddy[COORD_W-1:0];

    assign w_at_end = r_busy && (r_x == r_xe) && (r_y == r_ye);
    assign w_vis    = r_busy && !w_at_end && on_screen(r_x, r_y);

    assign w_e2    = {r_err, 1'b0};
    assign w_ndy_e = -$signed({3'b000, r_dy});
    assign w_dx_e  = $signed({3'b000, r_dx});
    assign w_mx    = w_e2 > w_ndy_e;
    assign w_my    = w_e2 < w_dx_e;
    assign w_err_a = w_mx ? r_err - $signed({2'b00, r_dy}) : r_err;

    always_comb begin
        n_busy  = r_busy;
        n_x     = r_x;
        n_y     = r_y;
        n_err   = r_err;
        n_count = r_count;
        if (!r_busy) begin
            if (i_start) begin
                n_busy  = 1'b1;
                n_x     = i_cmd.start_x;
                n_y     = i_cmd.start_y;
                n_err   = $signed({2'b00, w_adx}) - $signed({2'b00, w_ady});
                n_count = '0;
            end
        end else if (w_at_end) begin
            if (i_release) begin
                n_busy = 1'b0;
            end
        end else begin
            n_err = w_my ? w_err_a + $signed({2'b00, r_dx}) : w_err_a;
            if (w_mx) begin
                n_x = r_sx_neg ? r_x - COORD_W'(1) : r_x + COORD_W'(1);
            end
            if (w_my) begin
                n_y = r_sy_neg ? r_y - COORD_W'(1) : r_y + COORD_W'(1);
            end
            if (w_vis) begin
                n_count = r_count + COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
        r_x     <= n_x;
        r_y     <= n_y;
        r_err   <= n_err;
        r_count <= n_count;
        if (!r_busy && i_start) begin
            r_xe     <= i_cmd.end_x;
            r_ye     <= i_cmd.end_y;
            r_dx     <= w_adx;
            r_dy     <= w_ady;
            r_sx_neg <= w_ddx[COORD_W] || (w_ddx == '0);
            r_sy_neg <= w_ddy[COORD_W] || (w_ddy == '0);
            r_color  <= i_cmd.pixel_color;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = w_at_end;
    assign o_count     = r_count;
    assign o_wr.we     = w_vis;
    assign o_wr.addr   = pix_addr(r_x, r_y);
    assign o_wr.data   = r_color;

    // Every step short of the end point moves along at least one axis.
    `LRFB_ASSERT(a_step_moves, (r_busy && !w_at_end) |=> (r_x != $past(r_x) || r_y != $past(r_y)))
    // Finished line holds its position until released.
    `LRFB_ASSERT(a_end_holds, (w_at_end && !i_release) |=> (w_at_end && $stable(r_count)))

endmodule

// ----- hw/rtl/line_rasterizer_framebuffer_core.sv -----
// Line rasterizer core: 320x240 RGB565 frame store with line draw and pixel read.
// Depends on lrfb_pkg, lrfb_frame_ram, lrfb_line_stepper and the macro header.
//
//  channel | direction | handshake                 | payload
//  in      | into core | i_in_valid / o_in_ready   | i_in_item  (t_in_item)
//  out     | from core | o_out_valid / i_out_ready | o_out_item (t_out_item)
//
// Draw: the stepper issues one frame write per visited on-screen point short of the end point.
// Read: the frame RAM's registered read starts on acceptance; S_READ takes its data as the result.
// One item is in work at a time; the output register lets the next item start
// while a result waits. A finished item waits in place while the output is stalled.
// Reset clears control only; the frame contents are undefined until written.
`include "line_rasterizer_framebuffer_core_macros.svh"

module line_rasterizer_framebuffer_core
    import lrfb_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DRAW,
        S_READ
    } t_state;

    t_state    r_state;
    logic      r_out_valid;
    t_out_item r_out_item;
    logic      r_rd_hit;

    logic       w_accept, w_out_free, w_rd_hit;
    logic       w_start, w_re, w_release;
    t_step_stat w_step;
    t_wr_req    w_wr;
    logic [COUNT_W-1:0] w_count;
    logic [ADDR_W-1:0]  w_ram_addr;
    logic [COLOR_W-1:0] w_rdata;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_rd_hit   = on_screen(i_in_item.start_x, i_in_item.start_y);
    assign w_start    = w_accept && (i_in_item.op == OP_DRAW);
    assign w_re       = w_accept && (i_in_item.op == OP_READ) && w_rd_hit;
    assign w_release  = (r_state == S_DRAW) && w_out_free;
    assign w_ram_addr = w_wr.we ? w_wr.addr : pix_addr(i_in_item.start_x, i_in_item.start_y);

    lrfb_frame_ram #(
        .DEPTH  (FRAME_WORDS),
        .DATA_W (COLOR_W),
        .ADDR_W (ADDR_W)
    ) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (w_wr.we),
        .i_re    (w_re),
        .i_addr  (w_ram_addr),
        .i_wdata (w_wr.data),
        .o_rdata (w_rdata)
    );

    lrfb_line_stepper u_stepper (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_start),
        .i_cmd     (i_in_item),
        .i_release (w_release),
        .o_stat    (w_step),
        .o_count   (w_count),
        .o_wr      (w_wr)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_rd_hit <= w_rd_hit;
                        r_state  <= (i_in_item.op == OP_READ) ? S_READ : S_DRAW;
                    end
                end
                S_DRAW: begin
                    if (w_step.done && w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_item  <= '{read_pixel: '0, pixels_written: w_count};
                        r_state     <= S_IDLE;
                    end
                end
                S_READ: begin
                    // RAM data holds until the next access, so a stall just waits here
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_item  <= '{read_pixel: r_rd_hit ? w_rdata : '0,
                                         pixels_written: '0};
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // New items only enter while the stepper is free.
    `LRFB_ASSERT(a_ready_idle, o_in_ready |-> !w_step.busy)
    // Reads never race a frame write.
    `LRFB_ASSERT_NEVER(a_read_vs_write, (r_state == S_READ) && w_wr.we)
    // Each result carries either a pixel or a count, never both.
    `LRFB_ASSERT(a_one_field, o_out_valid |-> (o_out_item.read_pixel == '0 || o_out_item.pixels_written == '0))
    // A draw in progress always has its stepper busy.
    `LRFB_ASSERT(a_draw_busy, (r_state == S_DRAW) |-> w_step.busy)

endmodule
